// ----- src/ascending_integer_sorter_defines.svh -----
// ============================================================================
// Assertion macros for the ascending integer sorter
// Shared property forms used by the port-level checker.
// ============================================================================
`ifndef ASCENDING_INTEGER_SORTER_DEFINES_SVH
`define ASCENDING_INTEGER_SORTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define AIS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ais: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define AIS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ais: next-cycle check failed");

`endif

// ----- src/ais_pkg.sv -----
// ============================================================================
// Ascending integer sorter package
// Sizes, data type and the queue entry shared by the sorter modules.
// ============================================================================
`default_nettype none

package ais_pkg;

    // Buffer depth and element width.
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    // Index into the buffer and count that can also hold DEPTH itself.
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Queue between front and back; depth is a power of two so pointers wrap.
    localparam int QPTR_W = 2;
    localparam int QDEPTH = 1 << QPTR_W;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    // One classified element on its way to the back end.
    typedef struct packed {
        data_t value;
        logic  last;   // closes the set
        logic  store;  // element fits in the buffer
        logic  drop;   // set has lost an element so far, this one included
    } qentry_t;

    // Queue handshake as seen by one side.
    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } qxfer_t;

endpackage

`default_nettype wire

// ----- src/ais_if.sv -----
// ============================================================================
// Ascending integer sorter channels
// Valid/ready channels for input elements and sorted results.
// ============================================================================
`default_nettype none

// Input elements: one transfer per element.
interface ais_in_if;
    logic          valid;
    logic          ready;
    ais_pkg::data_t value;
    logic          last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

// Sorted results: one transfer per element, ascending.
interface ais_out_if;
    logic          valid;
    logic          ready;
    ais_pkg::data_t sorted_value;
    logic          last_out;
    logic          overflow;

    modport source (output valid, output sorted_value, output last_out,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_out,
                    input overflow, output ready);
endinterface

`default_nettype wire

// ----- src/ascending_integer_sorter.sv -----
// ============================================================================
// Ascending integer sorter
// Collects a set of signed integers and returns it in ascending order.
// ============================================================================
// Elements arrive one per transfer, and the element with last_in set closes
// the set. The front end takes one element per cycle as long as its
// four-entry queue has room; the back end drains that queue into a 64-entry
// buffer at one element per cycle while loading. Once a set is closed the
// back end sorts it with bubble passes over the buffer: at most n-1 passes
// run for n elements, and the sort stops after the first pass with no swap.
// The results then leave one at a time through an output register.
// While the back end sorts or emits, the front end keeps taking elements of
// the next set until the queue fills. Elements beyond the buffer depth are
// dropped and every result of that set carries overflow. No clearing pass is
// needed after reset.
`default_nettype none

module ascending_integer_sorter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ais_in_if.sink     in_items,
    ais_out_if.source  out_items
);

    ais_pkg::qxfer_t push;
    ais_pkg::qxfer_t pop;
    logic            push_ready;
    logic            pop_ready;

    // Classify incoming elements.
    ais_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_items   (in_items),
        .push       (push),
        .push_ready (push_ready)
    );

    // Decouple front and back.
    ais_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    // Store, sort and emit.
    ais_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (pop),
        .pop_ready  (pop_ready),
        .out_items  (out_items)
    );

endmodule

`default_nettype wire

// ----- src/ais_front.sv -----
// ============================================================================
// Sorter front end
// Accepts elements, tracks buffer fill per set and marks dropped elements.
// ============================================================================
`default_nettype none

module ais_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ais_in_if.sink           in_items,
    output ais_pkg::qxfer_t  push,
    input  wire logic        push_ready
);

    logic [ais_pkg::CNT_W-1:0] fcount_reg, fcount_next;
    logic                      fdrop_reg, fdrop_next;
    logic                      fits;
    logic                      xfer;

    // An element fits while the set holds fewer than DEPTH elements.
    assign fits = (fcount_reg < ais_pkg::CNT_W'(ais_pkg::DEPTH));
    assign xfer = in_items.valid && push_ready;

    assign in_items.ready    = push_ready;
    assign push.valid        = in_items.valid;
    assign push.entry.value  = in_items.value;
    assign push.entry.last   = in_items.last_in;
    assign push.entry.store  = fits;
    assign push.entry.drop   = fdrop_reg || !fits;

    // Per-set fill count and drop flag; both restart after the closing element.
    always_comb
    begin
        fcount_next = fcount_reg;
        fdrop_next  = fdrop_reg;
        if (xfer)
        begin
            if (in_items.last_in)
            begin
                fcount_next = '0;
                fdrop_next  = 1'b0;
            end
            else
            begin
                fcount_next = fcount_reg + {{(ais_pkg::CNT_W-1){1'b0}}, fits};
                fdrop_next  = fdrop_reg || !fits;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg <= '0;
            fdrop_reg  <= 1'b0;
        end
        else
        begin
            fcount_reg <= fcount_next;
            fdrop_reg  <= fdrop_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/ais_fifo.sv -----
// ============================================================================
// Sorter element queue
// Short first-in first-out queue between the front and the back end.
// ============================================================================
`default_nettype none

module ais_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ais_pkg::qxfer_t push,
    output logic                 push_ready,
    output ais_pkg::qxfer_t      pop,
    input  wire logic            pop_ready
);

    ais_pkg::qentry_t           entry_reg [ais_pkg::QDEPTH];
    logic [ais_pkg::QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [ais_pkg::QPTR_W:0]   fill_reg;
    logic                       do_push, do_pop;

    assign push_ready = (fill_reg != (ais_pkg::QPTR_W+1)'(ais_pkg::QDEPTH));
    assign pop.valid  = (fill_reg != '0);
    assign pop.entry  = entry_reg[rptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push.entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/ais_back.sv -----
// ============================================================================
// Sorter back end
// Stores a set, sorts it with early-exit bubble passes and emits it.
// ============================================================================
`default_nettype none

module ais_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ais_pkg::qxfer_t pop,
    output logic                 pop_ready,
    ais_out_if.source            out_items
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PINIT,
        S_PFIRST,
        S_PRUN,
        S_PEND,
        S_ERD,
        S_EHOLD
    } state_t;

    state_t                    state_reg, state_next;
    logic [ais_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [ais_pkg::IDX_W-1:0] lim_reg, lim_next;
    logic [ais_pkg::IDX_W-1:0] nlast_reg, nlast_next;
    logic [ais_pkg::IDX_W-1:0] k_reg, k_next;
    logic [ais_pkg::IDX_W-1:0] e_reg, e_next;
    ais_pkg::data_t            cur_reg, cur_next;
    logic                      swapped_reg, swapped_next;
    logic                      ovf_reg, ovf_next;
    logic                      out_valid_reg, out_valid_next;
    ais_pkg::data_t            out_value_reg, out_value_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_ovf_reg, out_ovf_next;

    // Element buffer with one write and one registered read port.
    ais_pkg::data_t            mem [ais_pkg::DEPTH];
    ais_pkg::data_t            rd_data_reg;
    logic [ais_pkg::IDX_W-1:0] rd_addr;
    logic [ais_pkg::IDX_W-1:0] wr_addr;
    ais_pkg::data_t            wr_data;
    logic                      wr_en;

    logic [ais_pkg::CNT_W-1:0] set_size;
    logic [ais_pkg::CNT_W-1:0] set_size_m1;
    logic                      out_free;

    assign out_items.valid        = out_valid_reg;
    assign out_items.sorted_value = out_value_reg;
    assign out_items.last_out     = out_last_reg;
    assign out_items.overflow     = out_ovf_reg;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_items.ready;

    // Size of the set once the element at the queue head is stored.
    assign set_size    = cnt_reg + {{(ais_pkg::CNT_W-1){1'b0}}, pop.entry.store};
    assign set_size_m1 = set_size - 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer: load, bubble passes carrying the running maximum, emit.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        nlast_next     = nlast_reg;
        k_next         = k_reg;
        e_next         = e_reg;
        cur_next       = cur_reg;
        swapped_next   = swapped_reg;
        ovf_next       = ovf_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !out_items.ready;
        pop_ready      = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = pop.entry.value;

        unique case (state_reg)
            S_LOAD:
            begin
                pop_ready = 1'b1;
                if (pop.valid)
                begin
                    wr_en    = pop.entry.store;
                    wr_addr  = cnt_reg[ais_pkg::IDX_W-1:0];
                    cnt_next = set_size;
                    if (pop.entry.last)
                    begin
                        cnt_next   = '0;
                        ovf_next   = pop.entry.drop;
                        lim_next   = set_size_m1[ais_pkg::IDX_W-1:0];
                        nlast_next = set_size_m1[ais_pkg::IDX_W-1:0];
                        e_next     = '0;
                        if (set_size_m1 == '0)
                        begin
                            state_next = S_ERD;
                        end
                        else
                        begin
                            state_next = S_PINIT;
                        end
                    end
                end
            end

            // Start a pass by reading the first entry.
            S_PINIT:
            begin
                rd_addr      = '0;
                k_next       = {{(ais_pkg::IDX_W-1){1'b0}}, 1'b1};
                swapped_next = 1'b0;
                state_next   = S_PFIRST;
            end

            S_PFIRST:
            begin
                rd_addr    = k_reg;
                cur_next   = rd_data_reg;
                state_next = S_PRUN;
            end

            // Compare the carried element with entry k and write back the smaller.
            S_PRUN:
            begin
                rd_addr = k_reg + 1'b1;
                wr_en   = 1'b1;
                wr_addr = k_reg - 1'b1;
                if (cur_reg > rd_data_reg)
                begin
                    wr_data      = rd_data_reg;
                    swapped_next = 1'b1;
                end
                else
                begin
                    wr_data  = cur_reg;
                    cur_next = rd_data_reg;
                end
                if (k_reg == lim_reg)
                begin
                    state_next = S_PEND;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            // Park the pass maximum; stop if the pass swapped nothing or was the last.
            S_PEND:
            begin
                wr_en   = 1'b1;
                wr_addr = lim_reg;
                wr_data = cur_reg;
                if (!swapped_reg || (lim_reg == {{(ais_pkg::IDX_W-1){1'b0}}, 1'b1}))
                begin
                    e_next     = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    lim_next   = lim_reg - 1'b1;
                    state_next = S_PINIT;
                end
            end

            S_ERD:
            begin
                rd_addr    = e_reg;
                state_next = S_EHOLD;
            end

            // Hand one sorted element to the output register.
            S_EHOLD:
            begin
                rd_addr = e_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rd_data_reg;
                    out_last_next  = (e_reg == nlast_reg);
                    out_ovf_next   = ovf_reg;
                    if (e_reg == nlast_reg)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        e_next     = e_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg       <= lim_next;
        nlast_reg     <= nlast_next;
        k_reg         <= k_next;
        e_reg         <= e_next;
        cur_reg       <= cur_next;
        swapped_reg   <= swapped_next;
        ovf_reg       <= ovf_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

`default_nettype wire

// ----- src/ais_checker.sv -----
// ============================================================================
// Sorter port checker
// Checks stall hold, order, flag consistency and set length on the result channel.
// ============================================================================
`default_nettype none

`include "ascending_integer_sorter_defines.svh"

module ais_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           out_valid,
    input  wire logic           out_ready,
    input  wire ais_pkg::data_t sorted_value,
    input  wire logic           last_out,
    input  wire logic           overflow
);

    logic                      xfer;
    logic                      stall;
    logic                      mid_reg;
    logic [ais_pkg::IDX_W-1:0] seen_reg;
    ais_pkg::data_t            prev_reg;
    logic                      ovf_reg;

    assign xfer  = out_valid && out_ready;
    assign stall = out_valid && !out_ready;

    // Track the set in progress on the result channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg  <= 1'b0;
            seen_reg <= '0;
        end
        else if (xfer)
        begin
            mid_reg  <= !last_out;
            seen_reg <= last_out ? '0 : seen_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            prev_reg <= sorted_value;
            ovf_reg  <= overflow;
        end
    end

    // A stalled result holds still.
    `AIS_ASSERT_NEXT(a_stall_hold, stall, out_valid && $stable({sorted_value, last_out, overflow}))

    // Results of one set never decrease.
    `AIS_ASSERT_IMP(a_ascending, xfer && mid_reg, sorted_value >= prev_reg)

    // The overflow flag is the same on every result of a set.
    `AIS_ASSERT_IMP(a_ovf_const, xfer && mid_reg, overflow == ovf_reg)

    // A set never runs longer than the buffer.
    `AIS_ASSERT_IMP(a_set_len, xfer && (seen_reg == ais_pkg::IDX_W'(ais_pkg::DEPTH - 1)), last_out)

endmodule

bind ascending_integer_sorter ais_checker u_ais_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_items.valid),
    .out_ready    (out_items.ready),
    .sorted_value (out_items.sorted_value),
    .last_out     (out_items.last_out),
    .overflow     (out_items.overflow)
);

`default_nettype wire
